### hdl/statistic_counter_table_unit_defines.svh
`ifndef STATISTIC_COUNTER_TABLE_UNIT_DEFINES_SVH
`define STATISTIC_COUNTER_TABLE_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define SCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sct assertion failed");

// Property that must hold in the cycle after its antecedent.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sct assertion failed");

`endif

### hdl/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int SCT_ID_COUNT  = 256;
  localparam int SCT_KEY_COUNT = 64;

  localparam logic OPC_UPDATE = 1'b0;
  localparam logic OPC_QUERY  = 1'b1;

  localparam logic [1:0] KIND_INC = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_MAX = 2'd2;
  localparam logic [1:0] KIND_MIN = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;

  localparam logic [2:0] TAG_NONE = 3'd0;

  typedef struct packed {
    logic [2:0]  tag;
    logic [31:0] val;
  } sct_entry_t;

  function automatic logic [2:0] kind_tag(input logic [1:0] kind);
    return {1'b0, kind} + 3'd1;
  endfunction

  function automatic logic tag_ok(input logic [2:0] tag, input logic [1:0] kind);
    return (tag == TAG_NONE) || (tag == kind_tag(kind));
  endfunction

  function automatic logic [31:0] upd_value(input logic [1:0] kind,
                                            input logic [31:0] old,
                                            input logic [31:0] operand);
    logic [31:0] res;
    res = old;
    case (kind)
      KIND_INC: res = old + operand;
      KIND_SET: res = operand;
      KIND_MAX: if (operand > old) res = operand;
      default: begin
        if ((operand < old) || ((old == 32'd0) && (operand != 32'd0))) res = operand;
      end
    endcase
    return res;
  endfunction

  function automatic logic [31:0] query_value(input logic [1:0] kind,
                                              input logic [31:0] act,
                                              input logic [31:0] oth);
    logic [31:0] res;
    case (kind)
      KIND_INC: res = act + oth;
      KIND_SET: res = act;
      KIND_MAX: res = (act > oth) ? act : oth;
      default:  res = (act < oth) ? act : oth;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/sct_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_bank
  import sct_pkg::*;
#(
  parameter int AW = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire sct_entry_t    wdata,
  input  wire logic [AW-1:0] raddr,
  output sct_entry_t         rdata
);

  sct_entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/statistic_counter_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "statistic_counter_table_unit_defines.svh"

// Double-banked statistics table. A command beat is taken at a clock edge where start
// is high and busy is low; opcode selects update or query, attr_id and attr_key select
// the entry, value is the update operand and op_kind the operation.
// Each command gives exactly one result beat on status and read_value, marked by done
// for one cycle. done rises at the edge after the command was taken.
// A new command may be taken every cycle while busy is low. Each bank is a memory with
// one read port and one write port; the update written back at one edge is forwarded
// to the command whose read was issued at that same edge, so back-to-back hits on one
// entry are exact.
// After reset, busy stays high while both banks are cleared, one entry per cycle,
// over all 2**(ID_W + KEY_W) addresses, each width being clog2 of its count and at
// least one (16384 entries per bank with the defaults).
// Queries read both banks at once. cfg_wen with cfg_wdata sets the active bank; write it
// only when no command is in flight. There is no back-pressure on results: done must
// be sampled in the cycle that it is high.
module statistic_counter_table_unit
  import sct_pkg::*;
#(
  parameter int ID_COUNT  = SCT_ID_COUNT,
  parameter int KEY_COUNT = SCT_KEY_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [8:0]  attr_id,
  input  wire logic [6:0]  attr_key,
  input  wire logic [31:0] value,
  input  wire logic [1:0]  op_kind,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      read_value
);

  localparam int ID_W  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int AW    = ID_W + KEY_W;

  logic          active_bank;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic          s1_valid;
  logic          s1_opcode;
  logic [1:0]    s1_kind;
  logic [31:0]   s1_value;
  logic          s1_range_err;
  logic [AW-1:0] s1_addr;

  logic          fwd_valid;
  logic          fwd_bank;
  logic [AW-1:0] fwd_addr;
  sct_entry_t    fwd_word;

  logic          accept;
  logic          range_err;
  logic [AW-1:0] raddr;
  sct_entry_t    rdata0, rdata1;
  sct_entry_t    word0, word1, act_word, oth_word;
  logic          upd_we;
  sct_entry_t    upd_word;
  logic          we0, we1;
  logic [AW-1:0] waddr;
  sct_entry_t    wdata;
  logic [1:0]    status_next;
  logic [31:0]   read_value_next;

  assign busy   = clearing;
  assign accept = start && !busy;

  assign range_err = ({1'b0, attr_id} >= 10'(ID_COUNT)) || ({1'b0, attr_key} >= 8'(KEY_COUNT));
  assign raddr     = {attr_id[ID_W-1:0], attr_key[KEY_W-1:0]};

  always_comb begin
    word0 = rdata0;
    word1 = rdata1;
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      if (fwd_bank) begin
        word1 = fwd_word;
      end else begin
        word0 = fwd_word;
      end
    end
    act_word = active_bank ? word1 : word0;
    oth_word = active_bank ? word0 : word1;

    upd_we          = 1'b0;
    upd_word.tag    = kind_tag(s1_kind);
    upd_word.val    = upd_value(s1_kind, act_word.val, s1_value);
    status_next     = ST_OK;
    read_value_next = 32'd0;
    if (s1_range_err) begin
      status_next = ST_RANGE;
    end else if (s1_opcode == OPC_UPDATE) begin
      if (!tag_ok(act_word.tag, s1_kind)) begin
        status_next = ST_CONFLICT;
      end else begin
        upd_we = s1_valid;
      end
    end else begin
      if (!tag_ok(act_word.tag, s1_kind) || !tag_ok(oth_word.tag, s1_kind)) begin
        status_next = ST_CONFLICT;
      end else begin
        read_value_next = query_value(s1_kind, act_word.val, oth_word.val);
      end
    end
  end

  assign we0   = clearing || (upd_we && !active_bank);
  assign we1   = clearing || (upd_we && active_bank);
  assign waddr = clearing ? clr_addr : s1_addr;
  assign wdata = clearing ? '0 : upd_word;

  sct_bank #(.AW(AW)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  sct_bank #(.AW(AW)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        active_bank <= cfg_wdata;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      s1_valid  <= accept;
      fwd_valid <= upd_we;
      done      <= s1_valid;
    end
    s1_opcode    <= opcode;
    s1_kind      <= op_kind;
    s1_value     <= value;
    s1_range_err <= range_err;
    s1_addr      <= raddr;
    fwd_bank     <= active_bank;
    fwd_addr     <= s1_addr;
    fwd_word     <= upd_word;
    status       <= status_next;
    read_value   <= read_value_next;
  end

  `SCT_ASSERT_IMPL(a_result_follows, clk, rst, accept, ##2 done)
  `SCT_ASSERT_IMPL(a_error_zero, clk, rst, done && (status != ST_OK), read_value == 32'd0)
  `SCT_ASSERT_IMPL(a_idle_while_clearing, clk, rst, clearing, !s1_valid && !done)
  `SCT_ASSERT_IMPL(a_one_bank_written, clk, rst, !clearing, !(we0 && we1))
  `SCT_ASSERT_NEXT(a_fwd_from_update, clk, rst, !upd_we, !fwd_valid)

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sct_pkg::*;

  localparam int BANK_ENTRIES = SCT_ID_COUNT * SCT_KEY_COUNT;
  localparam int HOT_COUNT = 16;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
  } stat_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [8:0]  attr_id;
  logic [6:0]  attr_key;
  logic [31:0] value;
  logic [1:0]  op_kind;
  logic        cfg_wen;
  logic        cfg_wdata;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_value;

  logic [31:0] stat_val [0:2*BANK_ENTRIES-1];
  logic [2:0]  stat_tag [0:2*BANK_ENTRIES-1];
  logic        model_bank;

  stat_result_t expected_results[$];
  int          fail_count;
  int          result_index;

  logic [8:0]  hot_id [0:HOT_COUNT-1];
  logic [6:0]  hot_key [0:HOT_COUNT-1];
  logic [1:0]  hot_kind [0:HOT_COUNT-1];

  statistic_counter_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .attr_id   (attr_id),
    .attr_key  (attr_key),
    .value     (value),
    .op_kind   (op_kind),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .status    (status),
    .read_value(read_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("statistic_counter_table_unit test failed");
    $finish;
  end

  function automatic stat_result_t predict_stat(input logic op, input logic [8:0] id,
                                                input logic [6:0] key,
                                                input logic [31:0] operand,
                                                input logic [1:0] kind);
    stat_result_t res;
    int           act_pos;
    int           oth_pos;
    logic [2:0]   want;
    logic [31:0]  cur;
    logic [31:0]  oth;
    res.status = ST_OK;
    res.read_value = '0;
    want = {1'b0, kind} + 3'd1;
    if (id >= SCT_ID_COUNT || key >= SCT_KEY_COUNT) begin
      res.status = ST_RANGE;
    end else begin
      act_pos = int'(model_bank) * BANK_ENTRIES + int'(id) * SCT_KEY_COUNT + int'(key);
      oth_pos = int'(!model_bank) * BANK_ENTRIES + int'(id) * SCT_KEY_COUNT + int'(key);
      cur = stat_val[act_pos];
      oth = stat_val[oth_pos];
      if (op == OPC_UPDATE) begin
        if (stat_tag[act_pos] != TAG_NONE && stat_tag[act_pos] != want) begin
          res.status = ST_CONFLICT;
        end else begin
          stat_tag[act_pos] = want;
          case (kind)
            KIND_INC: stat_val[act_pos] = cur + operand;
            KIND_SET: stat_val[act_pos] = operand;
            KIND_MAX: if (operand > cur) stat_val[act_pos] = operand;
            default: begin
              if (operand < cur || (cur == 32'd0 && operand != 32'd0)) begin
                stat_val[act_pos] = operand;
              end
            end
          endcase
        end
      end else begin
        if ((stat_tag[act_pos] != TAG_NONE && stat_tag[act_pos] != want) ||
            (stat_tag[oth_pos] != TAG_NONE && stat_tag[oth_pos] != want)) begin
          res.status = ST_CONFLICT;
        end else begin
          case (kind)
            KIND_INC: res.read_value = cur + oth;
            KIND_SET: res.read_value = cur;
            KIND_MAX: res.read_value = (cur > oth) ? cur : oth;
            default:  res.read_value = (cur < oth) ? cur : oth;
          endcase
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    stat_result_t want_r;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        if (fail_count < 10) begin
          $display("result beat %0d arrived with nothing expected: status %0d value %h",
                   result_index, status, read_value);
        end
        fail_count++;
      end else begin
        want_r = expected_results.pop_front();
        if (status !== want_r.status || read_value !== want_r.read_value) begin
          if (fail_count < 10) begin
            $display("result beat %0d: expected status %0d value %h, got status %0d value %h",
                     result_index, want_r.status, want_r.read_value, status, read_value);
          end
          fail_count++;
        end
      end
      result_index++;
    end
  end

  task automatic send_command(input logic op, input logic [8:0] id, input logic [6:0] key,
                              input logic [31:0] operand, input logic [1:0] kind);
    logic taken;
    start = 1'b1;
    opcode = op;
    attr_id = id;
    attr_key = key;
    value = operand;
    op_kind = kind;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (busy == 1'b0) begin
        expected_results.insert(expected_results.size(),
                                predict_stat(op, id, key, operand, kind));
        taken = 1'b1;
      end
    end
    @(negedge clk);
  endtask

  task automatic idle_cycle();
    start = 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_active_bank(input logic bank);
    cfg_wen = 1'b1;
    cfg_wdata = bank;
    @(negedge clk);
    cfg_wen = 1'b0;
    model_bank = bank;
  endtask

  task automatic test_reset_clear();
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    while (busy !== 1'b0) @(negedge clk);
    write_active_bank(1'b0);
  endtask

  task automatic test_single_bank_ops();
    send_command(OPC_UPDATE, 9'd0, 7'd0, 32'hFFFF_FFFF, KIND_INC);
    send_command(OPC_UPDATE, 9'd0, 7'd0, 32'd2, KIND_INC);
    send_command(OPC_QUERY, 9'd0, 7'd0, 32'd0, KIND_INC);
    send_command(OPC_UPDATE, 9'd0, 7'd0, 32'd9, KIND_SET);
    send_command(OPC_QUERY, 9'd0, 7'd0, 32'd0, KIND_MAX);
    send_command(OPC_UPDATE, 9'd255, 7'd63, 32'd5, KIND_MAX);
    send_command(OPC_UPDATE, 9'd255, 7'd63, 32'd3, KIND_MAX);
    send_command(OPC_QUERY, 9'd255, 7'd63, 32'd0, KIND_MAX);
    send_command(OPC_UPDATE, 9'd1, 7'd1, 32'd0, KIND_MIN);
    send_command(OPC_UPDATE, 9'd1, 7'd1, 32'd7, KIND_MIN);
    send_command(OPC_UPDATE, 9'd1, 7'd1, 32'd9, KIND_MIN);
    send_command(OPC_UPDATE, 9'd1, 7'd1, 32'd3, KIND_MIN);
    send_command(OPC_QUERY, 9'd1, 7'd1, 32'd0, KIND_MIN);
    send_command(OPC_UPDATE, 9'd2, 7'd2, 32'hDEAD_BEEF, KIND_SET);
    send_command(OPC_QUERY, 9'd2, 7'd2, 32'hFFFF_FFFF, KIND_SET);
    send_command(OPC_UPDATE, 9'd256, 7'd0, 32'd1, KIND_INC);
    send_command(OPC_UPDATE, 9'd0, 7'd64, 32'd1, KIND_SET);
    send_command(OPC_QUERY, 9'd511, 7'd127, 32'd0, KIND_SET);
    send_command(OPC_QUERY, 9'd0, 7'd64, 32'd0, KIND_MIN);
    wait_all_results();
  endtask

  task automatic test_bank_switch();
    write_active_bank(1'b1);
    send_command(OPC_UPDATE, 9'd0, 7'd0, 32'd10, KIND_INC);
    send_command(OPC_QUERY, 9'd0, 7'd0, 32'd0, KIND_INC);
    send_command(OPC_UPDATE, 9'd255, 7'd63, 32'hFFFF_FFFF, KIND_MAX);
    send_command(OPC_QUERY, 9'd255, 7'd63, 32'd0, KIND_MAX);
    send_command(OPC_UPDATE, 9'd1, 7'd1, 32'd5, KIND_MIN);
    send_command(OPC_QUERY, 9'd1, 7'd1, 32'd0, KIND_MIN);
    send_command(OPC_QUERY, 9'd2, 7'd2, 32'd0, KIND_SET);
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int beats, input int idle_pct, input logic bank);
    int          sel;
    int          h;
    logic        op;
    logic [8:0]  id;
    logic [6:0]  key;
    logic [31:0] operand;
    logic [1:0]  kind;
    wait_all_results();
    write_active_bank(bank);
    for (int n = 0; n < beats; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        h = $urandom_range(0, HOT_COUNT - 1);
        id = hot_id[h];
        key = hot_key[h];
        kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : hot_kind[h];
        op = ($urandom_range(0, 99) < 35) ? OPC_QUERY : OPC_UPDATE;
      end else if (sel < 90) begin
        id = 9'($urandom_range(0, SCT_ID_COUNT - 1));
        key = 7'($urandom_range(0, SCT_KEY_COUNT - 1));
        kind = 2'($urandom_range(0, 3));
        op = ($urandom_range(0, 1) != 0) ? OPC_QUERY : OPC_UPDATE;
      end else begin
        id = 9'($urandom_range(0, 511));
        key = 7'($urandom_range(0, 127));
        kind = 2'($urandom_range(0, 3));
        op = ($urandom_range(0, 1) != 0) ? OPC_QUERY : OPC_UPDATE;
      end
      case ($urandom_range(0, 7))
        0: operand = 32'd0;
        1: operand = 32'hFFFF_FFFF;
        2: operand = 32'($urandom_range(0, 15));
        default: operand = $urandom;
      endcase
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      send_command(op, id, key, operand, kind);
    end
    wait_all_results();
  endtask

  initial begin : main_sequence
    int waited;
    rst = 1'b1;
    start = 1'b0;
    opcode = OPC_UPDATE;
    attr_id = '0;
    attr_key = '0;
    value = '0;
    op_kind = KIND_INC;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    model_bank = 1'b0;
    fail_count = 0;
    result_index = 0;
    for (int i = 0; i < 2 * BANK_ENTRIES; i++) begin
      stat_val[i] = '0;
      stat_tag[i] = TAG_NONE;
    end
    for (int i = 0; i < HOT_COUNT; i++) begin
      hot_id[i] = 9'($urandom_range(0, SCT_ID_COUNT - 1));
      hot_key[i] = 7'($urandom_range(0, SCT_KEY_COUNT - 1));
      hot_kind[i] = 2'($urandom_range(0, 3));
    end

    test_reset_clear();
    test_single_bank_ops();
    test_bank_switch();
    test_random_traffic(150, 0, 1'b0);
    test_random_traffic(150, 62, 1'b1);
    test_random_traffic(75, 16, 1'b0);
    test_random_traffic(75, 16, 1'b0);
    test_random_traffic(150, 0, 1'b1);

    start = 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      if (fail_count < 10) begin
        $display("%0d expected result beats never arrived", expected_results.size());
      end
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("statistic_counter_table_unit test passed");
    end else begin
      $display("statistic_counter_table_unit test failed");
    end
    $finish;
  end

endmodule

### statistic_counter_table_unit.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_bank.sv
hdl/statistic_counter_table_unit.sv
bench/tb_top.sv
